// ----- design/keyboard_command_responder_assert.svh -----
// Assertion macros of the keyboard command responder checker.
// Depends on nothing; included by the checker file.
`ifndef KEYBOARD_COMMAND_RESPONDER_ASSERT_SVH
`define KEYBOARD_COMMAND_RESPONDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define KCR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("keyboard responder check failed");

// Next-cycle implication, disabled while reset is held.
`define KCR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("keyboard responder check failed");

`endif

// ----- design/kcr_pkg.sv -----
// Shared types, constants and helper functions of the keyboard command responder.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package kcr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int BYTE_W      = 8;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_INQ_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_REPLY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEST_REPLY  = 2'd2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd250;
    localparam logic [BYTE_W-1:0]    MODEL_RESET   = 8'h05;
    localparam logic [BYTE_W-1:0]    TEST_RESET    = 8'h7D;

    // Host commands.
    localparam logic [BYTE_W-1:0] CMD_POLL       = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_POLL_NOW   = 8'h14;
    localparam logic [BYTE_W-1:0] CMD_MODEL      = 8'h16;
    localparam logic [BYTE_W-1:0] CMD_SELF_CHECK = 8'h36;

    // Special reply codes.
    localparam logic [BYTE_W-1:0] CODE_NULL   = 8'h7B;
    localparam logic [BYTE_W-1:0] CODE_KEYPAD = 8'h79;

    localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX = '1;

    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_KEY  = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_NULL   = 2'd1,
        KIND_KEYPAD = 2'd2,
        KIND_FIXED  = 2'd3
    } kind_t;

    // Requests from the engine to the key queue.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] push_data;
    } queue_ctrl_t;

    // Status of the key queue seen by the engine.
    typedef struct packed {
        logic              empty;
        logic              full;
        logic [BYTE_W-1:0] head_data;
    } queue_stat_t;

    // Maps an arrow key (press or release) to its keypad code; zero otherwise.
    function automatic logic [BYTE_W-1:0] arrow_code(input logic [BYTE_W-1:0] k);
        logic [BYTE_W-1:0] rel;
        rel = k & 8'h80;
        case (k & 8'h7F)
            8'h7F:   arrow_code = 8'h0D | rel;
            8'h7E:   arrow_code = 8'h05 | rel;
            8'h7D:   arrow_code = 8'h1B | rel;
            8'h7C:   arrow_code = 8'h11 | rel;
            default: arrow_code = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- design/kcr_queue.sv -----
// Key FIFO of the keyboard command responder: register array with head and count.
// Depends on kcr_pkg.
`default_nettype none

module kcr_queue
    import kcr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire queue_ctrl_t ctrl,
    output queue_stat_t      stat
);

    localparam int SUM_W = QCNT_W + 1;

    logic [BYTE_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]  tail_sum;
    logic [QPTR_W-1:0] tail;

    always_comb begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail = tail_sum[QPTR_W-1:0];
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.pop) begin
            head_next  = (head_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end else if (ctrl.push) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Entries are only read after being written, so the array needs no reset.
    always_ff @(posedge aclk) begin
        if (ctrl.push && !ctrl.pop) begin
            mem_reg[tail] <= ctrl.push_data;
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.head_data = mem_reg[head_reg];

endmodule

`default_nettype wire

// ----- design/kcr_engine.sv -----
// Decision logic of the keyboard command responder: configuration registers,
// inquiry and keypad state, and the reply for one request. Depends on kcr_pkg.
`default_nettype none

module kcr_engine
    import kcr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  fire,
    input  wire op_t                   op,
    input  wire logic [BYTE_W-1:0]     cmd_byte,
    input  wire logic [BYTE_W-1:0]     key_byte,
    input  wire queue_stat_t           q_stat,
    output queue_ctrl_t                q_ctrl,
    output logic                       res_valid,
    output logic [BYTE_W-1:0]          res_byte,
    output kind_t                      res_kind
);

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [BYTE_W-1:0]    model_reg;
    logic [BYTE_W-1:0]    test_reg;

    logic                 inq_wait_reg, inq_wait_next;
    logic [TIMEOUT_W-1:0] elapsed_reg, elapsed_next;
    logic                 kp_wait_reg, kp_wait_next;
    logic [BYTE_W-1:0]    arrow_reg, arrow_next;

    logic [BYTE_W-1:0]    answer_src;
    logic [BYTE_W-1:0]    answer_arrow;
    logic [TIMEOUT_W-1:0] elapsed_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            model_reg   <= MODEL_RESET;
            test_reg    <= TEST_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_INQ_TIMEOUT: timeout_reg <= cfg_wdata;
                REG_MODEL_REPLY: model_reg   <= cfg_wdata[BYTE_W-1:0];
                REG_TEST_REPLY:  test_reg    <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // A key answering an inquiry comes either from the source or from the queue.
    assign answer_src   = (op == OP_KEY) ? key_byte : q_stat.head_data;
    assign answer_arrow = arrow_code(answer_src);
    assign elapsed_inc  = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb begin
        inq_wait_next    = inq_wait_reg;
        elapsed_next     = elapsed_reg;
        kp_wait_next     = kp_wait_reg;
        arrow_next       = arrow_reg;
        q_ctrl.push      = 1'b0;
        q_ctrl.pop       = 1'b0;
        q_ctrl.push_data = key_byte;
        res_valid        = 1'b0;
        res_byte         = '0;
        res_kind         = KIND_KEY;

        if (fire) begin
            case (op)
                OP_CMD: begin
                    if (kp_wait_reg) begin
                        kp_wait_next = 1'b0;
                        if (cmd_byte == CMD_POLL_NOW) begin
                            res_valid = 1'b1;
                            res_byte  = arrow_reg;
                        end
                    end else begin
                        inq_wait_next = 1'b0;
                        elapsed_next  = '0;
                        case (cmd_byte)
                            CMD_POLL: begin
                                if (!q_stat.empty) begin
                                    q_ctrl.pop = 1'b1;
                                    res_valid  = 1'b1;
                                    if (answer_arrow != '0) begin
                                        kp_wait_next = 1'b1;
                                        arrow_next   = answer_arrow;
                                        res_byte     = CODE_KEYPAD;
                                        res_kind     = KIND_KEYPAD;
                                    end else begin
                                        res_byte = answer_src;
                                    end
                                end else begin
                                    inq_wait_next = 1'b1;
                                end
                            end
                            CMD_POLL_NOW: begin
                                res_valid = 1'b1;
                                if (!q_stat.empty) begin
                                    q_ctrl.pop = 1'b1;
                                    res_byte   = q_stat.head_data;
                                end else begin
                                    res_byte = CODE_NULL;
                                    res_kind = KIND_NULL;
                                end
                            end
                            CMD_MODEL: begin
                                res_valid = 1'b1;
                                res_byte  = model_reg;
                                res_kind  = KIND_FIXED;
                            end
                            CMD_SELF_CHECK: begin
                                res_valid = 1'b1;
                                res_byte  = test_reg;
                                res_kind  = KIND_FIXED;
                            end
                            default: ;
                        endcase
                    end
                end
                OP_KEY: begin
                    if (inq_wait_reg) begin
                        inq_wait_next = 1'b0;
                        elapsed_next  = '0;
                        res_valid     = 1'b1;
                        if (answer_arrow != '0) begin
                            kp_wait_next = 1'b1;
                            arrow_next   = answer_arrow;
                            res_byte     = CODE_KEYPAD;
                            res_kind     = KIND_KEYPAD;
                        end else begin
                            res_byte = answer_src;
                        end
                    end else if (!q_stat.full) begin
                        q_ctrl.push = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (inq_wait_reg) begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= timeout_reg) begin
                            inq_wait_next = 1'b0;
                            elapsed_next  = '0;
                            res_valid     = 1'b1;
                            res_byte      = CODE_NULL;
                            res_kind      = KIND_NULL;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inq_wait_reg <= 1'b0;
            elapsed_reg  <= '0;
            kp_wait_reg  <= 1'b0;
            arrow_reg    <= '0;
        end else begin
            inq_wait_reg <= inq_wait_next;
            elapsed_reg  <= elapsed_next;
            kp_wait_reg  <= kp_wait_next;
            arrow_reg    <= arrow_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/keyboard_command_responder.sv -----
// Each request is decided in a single registered pass, from the input to the output register.
// Throughput: one request per cycle while the output register is free or being emptied.
// A request is accepted while a reply waits, as long as the input register can move on.
// Reset: aresetn is synchronous and active low; it empties the key queue, cancels any
// inquiry or keypad sequence and loads the registers with their default values.
// Top level of the keyboard command responder; depends on kcr_pkg, kcr_queue, kcr_engine.
`default_nettype none

module keyboard_command_responder
    import kcr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration write port: index 0 inquiry timeout in ms, 1 model reply, 2 test reply.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    // Request channel.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [7:0] cmd_byte, [15:8] key_byte
    input  wire logic [1:0]            s_tuser,   // [1:0] op

    // Reply channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] reply_byte
    output logic [1:0]                 m_tuser    // [1:0] reply_kind
);

    // Input register: holds one request until the decision stage takes it.
    logic              in_valid_reg, in_valid_next;
    op_t               in_op_reg;
    logic [BYTE_W-1:0] in_cmd_reg;
    logic [BYTE_W-1:0] in_key_reg;

    // Output register: holds one reply until the sink takes it.
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    kind_t             out_kind_reg;

    logic              s_fire;
    logic              proc_fire;
    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
    kind_t             res_kind;
    queue_ctrl_t       q_ctrl;
    queue_stat_t       q_stat;

    // The held request is decided when the output register is free or being emptied.
    // Requests that give no reply wait for the same condition, which keeps order simple.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (proc_fire) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg  <= op_t'(s_tuser);
            in_cmd_reg <= s_tdata[7:0];
            in_key_reg <= s_tdata[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && res_valid) begin
            out_byte_reg <= res_byte;
            out_kind_reg <= res_kind;
        end
    end

    kcr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .stat    (q_stat)
    );

    kcr_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (proc_fire),
        .op        (in_op_reg),
        .cmd_byte  (in_cmd_reg),
        .key_byte  (in_key_reg),
        .q_stat    (q_stat),
        .q_ctrl    (q_ctrl),
        .res_valid (res_valid),
        .res_byte  (res_byte),
        .res_kind  (res_kind)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;

endmodule

`default_nettype wire

// ----- design/kcr_checker.sv -----
// Port-level checker of the keyboard command responder and its bind statement.
// Depends on kcr_pkg and keyboard_command_responder_assert.svh.
`default_nettype none

`include "keyboard_command_responder_assert.svh"

module kcr_checker
    import kcr_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser
);

    // A stalled reply keeps its value.
    `KCR_ASSERT_NEXT(a_reply_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Requests are only held back when a reply is waiting and not taken.
    `KCR_ASSERT_NOW(a_ready_only_on_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

    // A null reply always carries the null code.
    `KCR_ASSERT_NOW(a_null_code, aclk, aresetn, m_tvalid && (m_tuser == KIND_NULL), m_tdata == CODE_NULL)

    // A keypad reply always carries the keypad prefix.
    `KCR_ASSERT_NOW(a_keypad_code, aclk, aresetn, m_tvalid && (m_tuser == KIND_KEYPAD), m_tdata == CODE_KEYPAD)

endmodule

bind keyboard_command_responder kcr_checker u_kcr_checker (.*);

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for keyboard_command_responder: random and directed host, key and tick
// requests are checked against a built-in predictor of the reply stream.
// Depends only on kcr_pkg and the keyboard_command_responder RTL.
`timescale 1ns / 100ps

module tb_top;
    import kcr_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int MAX_WAIT      = 14;
    localparam int RANDOM_BATCHES = 10;
    localparam int BATCH_REQUESTS = 180;

    // The op code that the block ignores; op_t leaves it out.
    localparam logic [1:0] OP_NONE = 2'd3;

    // Source arrow keys and the codes they stand for once the keypad prefix has gone out.
    localparam logic [7:0] SRC_ARROW_A = 8'h7F;
    localparam logic [7:0] SRC_ARROW_B = 8'h7E;
    localparam logic [7:0] SRC_ARROW_C = 8'h7D;
    localparam logic [7:0] SRC_ARROW_D = 8'h7C;
    localparam logic [7:0] PAD_ARROW_A = 8'h0D;
    localparam logic [7:0] PAD_ARROW_B = 8'h05;
    localparam logic [7:0] PAD_ARROW_C = 8'h1B;
    localparam logic [7:0] PAD_ARROW_D = 8'h11;
    localparam logic [7:0] RELEASE_BIT = 8'h80;

    // One entry of the request plan: a request to send, a wait for the block to go
    // quiet, or a register write.
    typedef enum logic [1:0] {
        STEP_REQ   = 2'd0,
        STEP_DRAIN = 2'd1,
        STEP_CFG   = 2'd2
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t            kind;
        logic                  gapless;
        logic [1:0]            op;
        logic [7:0]            cmd;
        logic [7:0]            key;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
    } plan_entry_t;

    typedef struct packed {
        logic [7:0] reply_byte;
        kind_t      reply_kind;
    } reply_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;   // [7:0] cmd_byte, [15:8] key_byte
    logic [1:0]            s_tuser   = '0;   // [1:0] op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [7:0] reply_byte
    logic [1:0]            m_tuser;          // [1:0] reply_kind

    plan_entry_t request_plan[$];
    reply_t      replies_due[$];

    // Settings the plan builder assumes, so that generated tick runs fit the timeout.
    logic        plan_gapless = 1'b0;
    logic [15:0] plan_timeout = TIMEOUT_RESET;

    // Predictor copy of the registers and of the responder state.
    logic [15:0] exp_timeout;
    logic [7:0]  exp_model;
    logic [7:0]  exp_test;
    logic        inq_wait;
    logic [15:0] inq_elapsed;
    logic        pad_wait;
    logic [7:0]  pad_code;
    logic [7:0]  key_store [QUEUE_DEPTH];
    int          store_head;
    int          store_count;

    // Driver and monitor bookkeeping.
    logic gap_drawn;
    int   gap_left;
    int   settle_left;
    int   stall_left;
    logic rx_quiet;
    int   failures          = 0;
    int   requests_accepted = 0;
    int   replies_checked   = 0;
    int   cfg_writes        = 0;

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Hard stop in case the block hangs or loses a reply.
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("TB_ERROR");
        $finish;
    end

    keyboard_command_responder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------
    // Reply predictor
    // ------------------------------------------------------------------

    function automatic void expect_reply(input logic [7:0] b, input kind_t k);
        reply_t r;
        r.reply_byte = b;
        r.reply_kind = k;
        replies_due.push_back(r);
    endfunction

    function automatic logic [7:0] take_oldest_key();
        logic [7:0] k;
        k = key_store[store_head];
        store_head  = (store_head + 1 >= QUEUE_DEPTH) ? 0 : store_head + 1;
        store_count = store_count - 1;
        return k;
    endfunction

    // An arrow key answering an Inquiry sends the keypad prefix and parks its code
    // for a following Instant; any other key goes out as it is.
    function automatic void answer_inquiry(input logic [7:0] k);
        logic [7:0] code;
        case (k & ~RELEASE_BIT)
            SRC_ARROW_A: code = PAD_ARROW_A;
            SRC_ARROW_B: code = PAD_ARROW_B;
            SRC_ARROW_C: code = PAD_ARROW_C;
            SRC_ARROW_D: code = PAD_ARROW_D;
            default:     code = '0;
        endcase
        if (code != '0) begin
            pad_wait = 1'b1;
            pad_code = code | (k & RELEASE_BIT);
            expect_reply(CODE_KEYPAD, KIND_KEYPAD);
        end else begin
            expect_reply(k, KIND_KEY);
        end
    endfunction

    function automatic void predict_reply(input logic [1:0] op, input logic [7:0] cmd,
                                          input logic [7:0] key);
        case (op)
            OP_CMD: begin
                if (pad_wait) begin
                    // The byte after a keypad prefix only finishes the sequence.
                    pad_wait = 1'b0;
                    if (cmd == CMD_POLL_NOW)
                        expect_reply(pad_code, KIND_KEY);
                end else begin
                    // Any command cancels a waiting Inquiry first.
                    inq_wait    = 1'b0;
                    inq_elapsed = '0;
                    case (cmd)
                        CMD_POLL: begin
                            if (store_count > 0)
                                answer_inquiry(take_oldest_key());
                            else
                                inq_wait = 1'b1;
                        end
                        CMD_POLL_NOW: begin
                            if (store_count > 0)
                                expect_reply(take_oldest_key(), KIND_KEY);
                            else
                                expect_reply(CODE_NULL, KIND_NULL);
                        end
                        CMD_MODEL:      expect_reply(exp_model, KIND_FIXED);
                        CMD_SELF_CHECK: expect_reply(exp_test, KIND_FIXED);
                        default: ;
                    endcase
                end
            end
            OP_KEY: begin
                if (inq_wait) begin
                    inq_wait    = 1'b0;
                    inq_elapsed = '0;
                    answer_inquiry(key);
                end else if (store_count < QUEUE_DEPTH) begin
                    key_store[(store_head + store_count) % QUEUE_DEPTH] = key;
                    store_count = store_count + 1;
                end
            end
            OP_TICK: begin
                if (inq_wait) begin
                    if (inq_elapsed != 16'hFFFF)
                        inq_elapsed = inq_elapsed + 16'd1;
                    if (inq_elapsed >= exp_timeout) begin
                        inq_wait    = 1'b0;
                        inq_elapsed = '0;
                        expect_reply(CODE_NULL, KIND_NULL);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver: walks the plan, draws an idle gap before each request,
    // holds a request until it is taken, and writes registers only once the
    // block has gone quiet.
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : driver
        logic        next_valid;
        logic        next_wr;
        plan_entry_t entry;
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            cfg_wr_en   <= 1'b0;
            gap_drawn   = 1'b0;
            gap_left    = 0;
            settle_left = -1;
            exp_timeout = TIMEOUT_RESET;
            exp_model   = MODEL_RESET;
            exp_test    = TEST_RESET;
            inq_wait    = 1'b0;
            inq_elapsed = '0;
            pad_wait    = 1'b0;
            pad_code    = '0;
            store_head  = 0;
            store_count = 0;
        end else begin
            next_valid = s_tvalid && !s_tready;
            next_wr    = 1'b0;
            // The request taken at this edge is predicted before anything new is set up.
            if (s_tvalid && s_tready) begin
                predict_reply(s_tuser, s_tdata[7:0], s_tdata[15:8]);
                requests_accepted++;
            end
            if (!next_valid && request_plan.size() > 0) begin
                case (request_plan[0].kind)
                    STEP_REQ: begin
                        if (!gap_drawn) begin
                            gap_drawn = 1'b1;
                            gap_left  = request_plan[0].gapless ? 0 :
                                        $urandom_range(0, MAX_WAIT);
                        end
                        if (gap_left == 0) begin
                            entry      = request_plan.pop_front();
                            next_valid = 1'b1;
                            gap_drawn  = 1'b0;
                            s_tdata   <= {entry.key, entry.cmd};
                            s_tuser   <= entry.op;
                        end else begin
                            gap_left--;
                        end
                    end
                    STEP_DRAIN: begin
                        // Wait for every reply, then let the settle count run down, for requests
                        // that give none but may still be in the pipeline.
                        if (replies_due.size() == 0) begin
                            if (settle_left < 0) begin
                                settle_left = SETTLE_CYCLES;
                            end else if (settle_left == 0) begin
                                void'(request_plan.pop_front());
                                settle_left = -1;
                            end else begin
                                settle_left--;
                            end
                        end
                    end
                    default: begin
                        entry      = request_plan.pop_front();
                        next_wr    = 1'b1;
                        cfg_index <= entry.reg_idx;
                        cfg_wdata <= entry.value;
                        cfg_writes++;
                        case (entry.reg_idx)
                            REG_INQ_TIMEOUT: exp_timeout = entry.value;
                            REG_MODEL_REPLY: exp_model   = entry.value[7:0];
                            REG_TEST_REPLY:  exp_test    = entry.value[7:0];
                            default: ;
                        endcase
                    end
                endcase
            end
            s_tvalid  <= next_valid;
            cfg_wr_en <= next_wr;
        end
    end

    // ------------------------------------------------------------------
    // Reply monitor: stalls at random after each reply, with quiet stretches,
    // and checks every reply against the oldest one predicted.
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : monitor
        reply_t due;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            rx_quiet   = 1'b0;
            stall_left = $urandom_range(0, MAX_WAIT);
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected reply: reply_byte %02h reply_kind %0d", m_tdata, m_tuser);
                    failures++;
                end else begin
                    due = replies_due.pop_front();
                    if (m_tdata !== due.reply_byte) begin
                        $error("reply_byte: expected %02h, actual %02h",
                               due.reply_byte, m_tdata);
                        failures++;
                    end
                    if (m_tuser !== due.reply_kind) begin
                        $error("reply_kind: expected %0d, actual %0d",
                               due.reply_kind, m_tuser);
                        failures++;
                    end
                end
                replies_checked++;
                if ($urandom_range(0, 49) == 0)
                    rx_quiet = !rx_quiet;
                stall_left = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (!m_tready && stall_left > 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Plan building
    // ------------------------------------------------------------------

    task automatic add_req(input logic [1:0] op, input logic [7:0] cmd, input logic [7:0] key);
        plan_entry_t e;
        e         = '0;
        e.kind    = STEP_REQ;
        e.gapless = plan_gapless;
        e.op      = op;
        e.cmd     = cmd;
        e.key     = key;
        request_plan.push_back(e);
    endtask

    task automatic add_drain();
        plan_entry_t e;
        e      = '0;
        e.kind = STEP_DRAIN;
        request_plan.push_back(e);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        plan_entry_t e;
        add_drain();
        e         = '0;
        e.kind    = STEP_CFG;
        e.reg_idx = idx;
        e.value   = val;
        request_plan.push_back(e);
        if (idx == REG_INQ_TIMEOUT)
            plan_timeout = val;
    endtask

    // A quarter of random keys are arrows, pressed or released.
    function automatic logic [7:0] rand_key();
        logic [7:0] k;
        k = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            k = {k[7], 5'b11111, k[1:0]};
        return k;
    endfunction

    // Mostly polling sequences the way a host runs them, with keys arriving in
    // bursts, plus stray commands, stray ticks and ignored requests as noise.
    task automatic add_traffic(input int n_requests);
        int         added;
        int         r;
        int         n;
        int         w;
        int         tick_cap;
        logic [7:0] c;
        added = 0;
        while (added < n_requests) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                add_req(OP_CMD, CMD_POLL, 8'($urandom));
                added++;
                w        = $urandom_range(0, 3);
                tick_cap = (plan_timeout > 16'd40) ? 42 : int'(plan_timeout) + 2;
                n        = (w == 0) ? 0 : $urandom_range(0, tick_cap);
                repeat (n) add_req(OP_TICK, 8'($urandom), 8'($urandom));
                added += n;
                if (w == 2) begin
                    add_req(OP_KEY, 8'($urandom), rand_key());
                    added++;
                end
            end else if (r < 45) begin
                add_req(OP_CMD, CMD_POLL_NOW, 8'($urandom));
                added++;
            end else if (r < 65) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
                repeat (n) add_req(OP_KEY, 8'($urandom), rand_key());
                added += n;
            end else if (r < 72) begin
                c = $urandom_range(0, 1) ? CMD_MODEL : CMD_SELF_CHECK;
                add_req(OP_CMD, c, 8'($urandom));
                added++;
            end else if (r < 80) begin
                add_req(OP_CMD, 8'($urandom), 8'($urandom));
                added++;
            end else if (r < 92) begin
                n = $urandom_range(1, 3);
                repeat (n) add_req(OP_TICK, 8'($urandom), 8'($urandom));
                added += n;
            end else begin
                // Ignored by the block, so not counted.
                add_req(OP_NONE, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial begin : stimulus
        int batch;

        // Directed requests under the reset settings.
        add_req(OP_CMD, CMD_MODEL, 8'($urandom));
        add_req(OP_CMD, CMD_SELF_CHECK, 8'($urandom));
        add_req(OP_CMD, CMD_POLL_NOW, 8'($urandom));  // empty queue: null code
        add_req(OP_CMD, 8'h00, 8'hFF);                // unknown commands: no reply
        add_req(OP_CMD, 8'hFF, 8'h00);
        add_req(OP_TICK, 8'hFF, 8'hFF);               // tick with no Inquiry waiting
        add_req(OP_NONE, 8'hFF, 8'hFF);               // ignored op
        add_req(OP_KEY, 8'h00, 8'h00);
        add_req(OP_KEY, 8'h00, SRC_ARROW_A | RELEASE_BIT);
        add_req(OP_KEY, 8'h00, SRC_ARROW_C);
        add_req(OP_CMD, CMD_POLL_NOW, 8'h00);         // oldest key as it is
        add_req(OP_CMD, CMD_POLL, 8'h00);             // arrow release: keypad prefix
        add_req(OP_CMD, CMD_POLL_NOW, 8'h00);         // mapped release code follows
        add_req(OP_CMD, CMD_POLL_NOW, 8'h00);         // queued arrow, no mapping
        add_req(OP_CMD, CMD_POLL, 8'h00);             // empty: starts waiting
        add_req(OP_KEY, 8'h00, SRC_ARROW_B);          // key ends the wait with a prefix
        add_req(OP_CMD, CMD_MODEL, 8'h00);            // not Instant: arrow dropped
        add_req(OP_CMD, CMD_POLL, 8'h00);
        add_req(OP_TICK, 8'h00, 8'h00);
        add_req(OP_KEY, 8'h00, 8'h41);                // plain key answers the wait
        add_req(OP_CMD, CMD_POLL, 8'h00);
        add_req(OP_CMD, CMD_SELF_CHECK, 8'h00);       // command cancels the wait
        add_req(OP_CMD, CMD_POLL, 8'h00);
        add_req(OP_CMD, CMD_POLL, 8'h00);             // waits again
        add_req(OP_KEY, 8'h00, SRC_ARROW_D);
        add_req(OP_CMD, CMD_POLL_NOW, 8'h00);

        // Timeouts of zero, one and three ticks.
        add_cfg(REG_INQ_TIMEOUT, 16'd0);
        add_req(OP_CMD, CMD_POLL, 8'h00);
        add_req(OP_TICK, 8'h00, 8'h00);
        add_cfg(REG_INQ_TIMEOUT, 16'd1);
        add_req(OP_CMD, CMD_POLL, 8'h00);
        add_req(OP_TICK, 8'h00, 8'h00);
        add_cfg(REG_INQ_TIMEOUT, 16'd3);
        add_req(OP_CMD, CMD_POLL, 8'h00);
        repeat (3) add_req(OP_TICK, 8'h00, 8'h00);

        // Fill the key queue past full, then empty it and read one more.
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            add_req(OP_KEY, 8'h00, 8'(8'h20 + i));
        repeat (QUEUE_DEPTH + 1) add_req(OP_CMD, CMD_POLL_NOW, 8'h00);

        // Fixed replies at both extremes.
        add_cfg(REG_MODEL_REPLY, 16'h0000);
        add_cfg(REG_TEST_REPLY, 16'h00FF);
        add_req(OP_CMD, CMD_MODEL, 8'h00);
        add_req(OP_CMD, CMD_SELF_CHECK, 8'h00);
        add_cfg(REG_MODEL_REPLY, 16'h00FF);
        add_cfg(REG_TEST_REPLY, 16'h0000);
        add_req(OP_CMD, CMD_MODEL, 8'h00);
        add_req(OP_CMD, CMD_SELF_CHECK, 8'h00);

        // Longest timeout: a run of ticks back to back stays far below it, and a
        // plain key then answers the waiting Inquiry.
        add_cfg(REG_INQ_TIMEOUT, 16'hFFFF);
        plan_gapless = 1'b1;
        add_req(OP_CMD, CMD_POLL, 8'h00);
        repeat (20) add_req(OP_TICK, 8'h00, 8'h00);
        add_req(OP_KEY, 8'h00, 8'h42);
        plan_gapless = 1'b0;

        // Random batches, each under fresh settings; every second batch of four
        // is sent back to back.
        for (batch = 0; batch < RANDOM_BATCHES; batch++) begin
            plan_gapless = (batch % 4 == 1);
            if (batch == 3)
                add_cfg(REG_INQ_TIMEOUT, 16'd0);
            else if (batch % 3 == 0)
                add_cfg(REG_INQ_TIMEOUT, 16'($urandom_range(13, 40)));
            else
                add_cfg(REG_INQ_TIMEOUT, 16'($urandom_range(1, 12)));
            add_cfg(REG_MODEL_REPLY, 16'($urandom_range(0, 255)));
            if (batch % 2 == 0)
                add_cfg(REG_TEST_REPLY, 16'($urandom_range(0, 255)));
            add_traffic(BATCH_REQUESTS);
        end
        plan_gapless = 1'b0;

        // Let the plan run out, then wait for the last replies and a short tail.
        @(posedge aclk);
        while (!aresetn || request_plan.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (replies_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d requests and checked %0d replies across %0d register writes,",
                 requests_accepted, replies_checked, cfg_writes);
        $display("covering keypad sequences, a full queue, and short, zero and longest timeouts.");
        if (failures == 0 && replies_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/kcr_pkg.sv
design/kcr_queue.sv
design/kcr_engine.sv
design/keyboard_command_responder.sv
design/kcr_checker.sv
bench/tb_top.sv
